// ----- rtl/scfr_pkg.sv -----
// ----------------------------------------------------------------------------
// scfr_pkg
// shared types, codes and the byte-wide crc step of the command frame receiver
// ----------------------------------------------------------------------------
package scfr_pkg;

  // frame limits and lookup width
  localparam int COMMAND_SLOTS   = 4;
  localparam int MAX_FRAME_BYTES = 256;

  localparam logic [7:0]  LEN_MIN  = 8'd5;
  localparam logic [7:0]  LEN_MAX  = 8'(MAX_FRAME_BYTES - 2);
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // byte positions inside the header
  localparam logic [7:0] POS_COMMAND = 8'd2;
  localparam logic [7:0] POS_PACKET  = 8'd3;
  localparam logic [7:0] POS_BODY    = 8'd5;

  // configuration port
  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [2:0] REG_HUNT_LIMIT    = 3'd2;
  localparam logic [2:0] REG_FRAME_LIMIT   = 3'd3;
  localparam logic [2:0] REG_COMMAND_CODES = 3'd4;
  localparam logic [2:0] REG_COMMAND_VALID = 3'd5;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h1b;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h10;
  localparam logic [31:0] TICK_LIMIT_RST  = 32'd100000;

  // input item codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result item kinds
  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK_LAST      = 3'd0,
    ST_OK_MORE      = 3'd1,
    ST_CRC_ERROR    = 3'd2,
    ST_UNKNOWN_CMD  = 3'd3,
    ST_HDR_TIMEOUT  = 3'd4,
    ST_BODY_TIMEOUT = 3'd5,
    ST_NO_DATA      = 3'd6,
    ST_BAD_LENGTH   = 3'd7
  } scfr_status_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ARMED  = 3'd1,
    PH_HEADER = 3'd2,
    PH_BODY   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5
  } scfr_phase_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [31:0] hunt_tick_limit;
    logic [31:0] frame_tick_limit;
    logic [31:0] command_codes;
    logic [3:0]  command_valid;
  } scfr_cfg_t;

  // crc-16, poly 0x8005, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    logic        top;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      top = c[15];
      c   = {c[14:0], 1'b0};
      if (top ^ data[7-k]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/scfr_if.sv -----
// ----------------------------------------------------------------------------
// scfr_if
// valid/ready channels for received items and frame results
// ----------------------------------------------------------------------------
interface scfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface scfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] param_byte;
  logic [2:0] status;
  logic [7:0] frame_command;
  logic [1:0] command_slot;
  logic [7:0] packet_number;

  modport source (output valid, output kind, output param_byte, output status,
                  output frame_command, output command_slot, output packet_number,
                  input ready);
  modport sink   (input valid, input kind, input param_byte, input status,
                  input frame_command, input command_slot, input packet_number,
                  output ready);
endinterface

// ----- rtl/serial_command_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// serial_command_frame_receiver_core
// sync hunt, header/body parse, crc-16 check, command lookup and tick timeouts
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  in_ch    | in  | valid/ready   | cmd (byte or tick), rx_byte
//  out_ch   | out | valid/ready   | kind, param_byte, status, frame_command,
//           |     |               | command_slot, packet_number
//  cfg      | in  | apb psel/pen. | six registers at byte address 4*index
//
//  an item goes through two registers: the input register, then the result
//  register; a result is written into the result register when the held item
//  is processed and the result register can advance
//  one item per cycle sustained while results are not stalled by out_ch.ready
//  rst_n is synchronous; it clears the frame state and timers and returns
//  the configuration registers to their default values
//  a stalled result holds the result register; the input register still
//  fills, then in_ch.ready drops until out_ch.ready returns
// ----------------------------------------------------------------------------
module serial_command_frame_receiver_core import scfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  scfr_in_if.sink               in_ch,
  scfr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  scfr_cfg_t cfg;

  scfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;
  logic       in_fire;
  logic       advance;   // result register can take a new value this cycle
  logic       s1_fire;   // held item gets processed this cycle

  logic       out_valid_r, out_valid_nxt;

  assign advance      = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && advance;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // frame state
  // ---------------------------------------------------------------------------
  scfr_phase_t phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [7:0]  held_pkt_r, held_pkt_nxt;
  logic [7:0]  held_len_r, held_len_nxt;
  logic        hi_match_r, hi_match_nxt;
  logic [31:0] tick_r, tick_nxt;

  logic [31:0]  tick_inc;
  logic [7:0]   pos_inc;
  logic [15:0]  crc_upd;
  logic         clear_frame;
  logic         slot_found;
  logic [1:0]   slot_idx;

  logic         res_valid;
  logic         res_kind;
  logic [7:0]   res_param;
  scfr_status_t res_status;
  logic [1:0]   res_slot;

  // saturating tick count
  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 32'd1;
  assign pos_inc  = pos_r + 8'd1;
  assign crc_upd  = crc_byte(crc_r, s1_byte_r);

  // first valid slot whose code matches, lowest index wins
  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int s = COMMAND_SLOTS - 1; s >= 0; s--) begin
      if (cfg.command_valid[s] && cfg.command_codes[8*s +: 8] == held_cmd_r) begin
        slot_found = 1'b1;
        slot_idx   = 2'(s);
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    held_cmd_nxt = held_cmd_r;
    held_pkt_nxt = held_pkt_r;
    held_len_nxt = held_len_r;
    hi_match_nxt = hi_match_r;
    tick_nxt     = tick_r;
    clear_frame  = 1'b0;
    res_valid    = 1'b0;
    res_kind     = KIND_STATUS;
    res_param    = '0;
    res_status   = ST_OK_LAST;
    res_slot     = '0;

    if (s1_fire) begin
      if (s1_cmd_r == CMD_TICK) begin
        tick_nxt = tick_inc;
        case (phase_r)
          PH_HUNT, PH_ARMED: begin
            if (tick_inc > cfg.hunt_tick_limit) begin
              res_valid  = 1'b1;
              res_status = ST_NO_DATA;
            end
          end
          PH_HEADER: begin
            if (tick_inc > cfg.frame_tick_limit) begin
              res_valid  = 1'b1;
              res_status = ST_HDR_TIMEOUT;
            end
          end
          default: begin
            if (tick_inc > cfg.frame_tick_limit) begin
              res_valid  = 1'b1;
              res_status = ST_BODY_TIMEOUT;
            end
          end
        endcase
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (s1_byte_r == cfg.sync_first) begin
              phase_nxt = PH_ARMED;
            end
          end
          PH_ARMED: begin
            // second sync takes priority when both sync bytes are equal
            if (s1_byte_r == cfg.sync_second) begin
              crc_nxt      = crc_byte(crc_byte(16'd0, cfg.sync_first), cfg.sync_second);
              held_cmd_nxt = '0;
              held_pkt_nxt = '0;
              held_len_nxt = '0;
              hi_match_nxt = 1'b0;
              pos_nxt      = POS_COMMAND;
              phase_nxt    = PH_HEADER;
            end else if (s1_byte_r != cfg.sync_first) begin
              phase_nxt = PH_HUNT;
            end
          end
          PH_HEADER: begin
            crc_nxt = crc_upd;
            if (pos_r == POS_COMMAND) begin
              held_cmd_nxt = s1_byte_r;
              pos_nxt      = POS_PACKET;
            end else if (pos_r == POS_PACKET) begin
              held_pkt_nxt = s1_byte_r;
              pos_nxt      = pos_inc;
            end else begin
              held_len_nxt = s1_byte_r;
              pos_nxt      = POS_BODY;
              if (s1_byte_r < LEN_MIN || s1_byte_r > LEN_MAX) begin
                res_valid  = 1'b1;
                res_status = ST_BAD_LENGTH;
              end else if (s1_byte_r == LEN_MIN) begin
                phase_nxt = PH_CRC_HI;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            crc_nxt   = crc_upd;
            pos_nxt   = pos_inc;
            if (pos_inc >= held_len_r) begin
              phase_nxt = PH_CRC_HI;
            end
            res_valid = 1'b1;
            res_kind  = KIND_PARAM;
            res_param = s1_byte_r;
          end
          PH_CRC_HI: begin
            hi_match_nxt = (s1_byte_r == crc_r[15:8]);
            phase_nxt    = PH_CRC_LO;
          end
          default: begin
            // crc before command lookup
            res_valid = 1'b1;
            if (!(hi_match_r && s1_byte_r == crc_r[7:0])) begin
              res_status = ST_CRC_ERROR;
            end else if (slot_found) begin
              res_status = (held_pkt_r != 8'd0) ? ST_OK_MORE : ST_OK_LAST;
              res_slot   = slot_idx;
            end else begin
              res_status = ST_UNKNOWN_CMD;
            end
          end
        endcase
      end

      // any status ends the frame and restarts the hunt
      clear_frame = res_valid && (res_kind == KIND_STATUS);
    end

    if (clear_frame) begin
      phase_nxt    = PH_HUNT;
      pos_nxt      = '0;
      crc_nxt      = '0;
      held_cmd_nxt = '0;
      held_pkt_nxt = '0;
      held_len_nxt = '0;
      hi_match_nxt = 1'b0;
      tick_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= '0;
      held_cmd_r <= '0;
      held_pkt_r <= '0;
      held_len_r <= '0;
      hi_match_r <= 1'b0;
      tick_r     <= '0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      held_cmd_r <= held_cmd_nxt;
      held_pkt_r <= held_pkt_nxt;
      held_len_r <= held_len_nxt;
      hi_match_r <= hi_match_nxt;
      tick_r     <= tick_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic         out_kind_r;
  logic [7:0]   out_param_r;
  scfr_status_t out_status_r;
  logic [7:0]   out_cmd_r;
  logic [1:0]   out_slot_r;
  logic [7:0]   out_pkt_r;

  // when advancing, the old result is gone (taken or never there)
  assign out_valid_nxt = advance ? (s1_fire && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame_command and packet_number are the values held before the clear
  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_kind_r   <= res_kind;
      out_param_r  <= res_param;
      out_status_r <= res_status;
      out_cmd_r    <= held_cmd_r;
      out_slot_r   <= res_slot;
      out_pkt_r    <= held_pkt_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.param_byte    = out_param_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.frame_command = out_cmd_r;
  assign out_ch.command_slot  = out_slot_r;
  assign out_ch.packet_number = out_pkt_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_status_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid && res_kind == KIND_STATUS) |=>
      (phase_r == PH_HUNT && tick_r == '0 && pos_r == '0))
    else $error("frame state not cleared after a status result");

  a_param_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid && res_kind == KIND_PARAM) |-> (phase_r == PH_BODY))
    else $error("parameter byte produced outside the frame body");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while the result register is empty");

  a_header_position: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |->
      (pos_r == POS_COMMAND || pos_r == POS_PACKET || pos_r == 8'd4))
    else $error("header byte position out of range");

  a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_cmd_r)))
    else $error("held input item lost during an output stall");

endmodule

// ----- rtl/scfr_regs.sv -----
// ----------------------------------------------------------------------------
// scfr_regs
// apb-style configuration registers of the command frame receiver
// ----------------------------------------------------------------------------
module scfr_regs import scfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output scfr_cfg_t             cfg
);

  scfr_cfg_t  cfg_r;
  scfr_cfg_t  cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SYNC_FIRST:    cfg_nxt.sync_first       = pwdata[7:0];
        REG_SYNC_SECOND:   cfg_nxt.sync_second      = pwdata[7:0];
        REG_HUNT_LIMIT:    cfg_nxt.hunt_tick_limit  = pwdata;
        REG_FRAME_LIMIT:   cfg_nxt.frame_tick_limit = pwdata;
        REG_COMMAND_CODES: cfg_nxt.command_codes    = pwdata;
        REG_COMMAND_VALID: cfg_nxt.command_valid    = pwdata[3:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first       <= SYNC_FIRST_RST;
      cfg_r.sync_second      <= SYNC_SECOND_RST;
      cfg_r.hunt_tick_limit  <= TICK_LIMIT_RST;
      cfg_r.frame_tick_limit <= TICK_LIMIT_RST;
      cfg_r.command_codes    <= '0;
      cfg_r.command_valid    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_FIRST:    prdata = {24'd0, cfg_r.sync_first};
      REG_SYNC_SECOND:   prdata = {24'd0, cfg_r.sync_second};
      REG_HUNT_LIMIT:    prdata = cfg_r.hunt_tick_limit;
      REG_FRAME_LIMIT:   prdata = cfg_r.frame_tick_limit;
      REG_COMMAND_CODES: prdata = cfg_r.command_codes;
      REG_COMMAND_VALID: prdata = {28'd0, cfg_r.command_valid};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- dv/scfr_frame_checker.sv -----
// ----------------------------------------------------------------------------
// scfr_frame_checker
// watches the item and result channels and the register port, predicts every
// result of the command frame receiver and compares it field by field
// ----------------------------------------------------------------------------
module scfr_frame_checker import scfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  scfr_in_if                    in_ch,
  scfr_out_if                   out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic         kind;
    logic [7:0]   param_byte;
    scfr_status_t status;
    logic [7:0]   frame_command;
    logic [1:0]   command_slot;
    logic [7:0]   packet_number;
  } frame_result_t;

  // shadow of the registers and of the frame state
  scfr_cfg_t     cfg_regs;
  scfr_phase_t   frame_phase;
  logic [7:0]    byte_pos;
  logic [15:0]   crc_acc;
  logic [7:0]    held_cmd;
  logic [7:0]    held_pkt;
  logic [7:0]    held_len;
  logic          crc_hi_ok;
  logic [31:0]   tick_cnt;
  frame_result_t expected_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // data folded into the top byte, then eight shifts
  function automatic logic [15:0] crc_update(logic [15:0] acc, logic [7:0] b);
    logic [15:0] v;
    v = acc ^ {b, 8'h00};
    repeat (8) v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
    return v;
  endfunction

  function automatic void clear_frame_state();
    frame_phase = PH_HUNT;
    byte_pos    = '0;
    crc_acc     = '0;
    held_cmd    = '0;
    held_pkt    = '0;
    held_len    = '0;
    crc_hi_ok   = 1'b0;
    tick_cnt    = '0;
  endfunction

  function automatic bit close_frame(scfr_status_t st, logic [1:0] slot,
                                     output frame_result_t r);
    r               = '0;
    r.kind          = KIND_STATUS;
    r.status        = st;
    r.frame_command = held_cmd;
    r.command_slot  = slot;
    r.packet_number = held_pkt;
    clear_frame_state();
    return 1'b1;
  endfunction

  function automatic bit predict_item(logic is_tick, logic [7:0] b, output frame_result_t r);
    logic [31:0] limit;
    r = '0;
    if (is_tick == CMD_TICK) begin
      if (tick_cnt != '1) tick_cnt++;
      if (frame_phase == PH_HUNT || frame_phase == PH_ARMED) begin
        if (tick_cnt > cfg_regs.hunt_tick_limit) return close_frame(ST_NO_DATA, 2'd0, r);
        return 1'b0;
      end
      limit = cfg_regs.frame_tick_limit;
      if (tick_cnt > limit)
        return close_frame(frame_phase == PH_HEADER ? ST_HDR_TIMEOUT : ST_BODY_TIMEOUT, 2'd0, r);
      return 1'b0;
    end
    case (frame_phase)
      PH_HUNT: begin
        if (b == cfg_regs.sync_first) frame_phase = PH_ARMED;
        return 1'b0;
      end
      PH_ARMED: begin
        // second sync wins when both sync bytes are equal
        if (b == cfg_regs.sync_second) begin
          crc_acc     = crc_update(crc_update(16'h0000, cfg_regs.sync_first),
                                   cfg_regs.sync_second);
          held_cmd    = '0;
          held_pkt    = '0;
          held_len    = '0;
          crc_hi_ok   = 1'b0;
          byte_pos    = POS_COMMAND;
          frame_phase = PH_HEADER;
        end else if (b != cfg_regs.sync_first) begin
          frame_phase = PH_HUNT;
        end
        return 1'b0;
      end
      PH_HEADER: begin
        crc_acc = crc_update(crc_acc, b);
        if (byte_pos == POS_COMMAND) begin
          held_cmd = b;
          byte_pos = POS_PACKET;
          return 1'b0;
        end
        if (byte_pos == POS_PACKET) begin
          held_pkt = b;
          byte_pos = POS_PACKET + 8'd1;
          return 1'b0;
        end
        held_len = b;
        byte_pos = POS_BODY;
        if (b < LEN_MIN || b > LEN_MAX) return close_frame(ST_BAD_LENGTH, 2'd0, r);
        frame_phase = (b == LEN_MIN) ? PH_CRC_HI : PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        crc_acc  = crc_update(crc_acc, b);
        byte_pos = byte_pos + 8'd1;
        if (byte_pos >= held_len) frame_phase = PH_CRC_HI;
        r.kind          = KIND_PARAM;
        r.param_byte    = b;
        r.status        = ST_OK_LAST;
        r.frame_command = held_cmd;
        r.packet_number = held_pkt;
        return 1'b1;
      end
      PH_CRC_HI: begin
        crc_hi_ok   = (b == crc_acc[15:8]);
        frame_phase = PH_CRC_LO;
        return 1'b0;
      end
      PH_CRC_LO: begin
        // crc first, then the first valid slot holding the command
        if (!(crc_hi_ok && b == crc_acc[7:0])) return close_frame(ST_CRC_ERROR, 2'd0, r);
        for (int s = 0; s < COMMAND_SLOTS && s < 4; s++) begin
          if (cfg_regs.command_valid[s] && cfg_regs.command_codes[8*s +: 8] == held_cmd)
            return close_frame(held_pkt != 8'd0 ? ST_OK_MORE : ST_OK_LAST, 2'(s), r);
        end
        return close_frame(ST_UNKNOWN_CMD, 2'd0, r);
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t nxt;
    if (!rst_n) begin
      cfg_regs = '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                   hunt_tick_limit: TICK_LIMIT_RST, frame_tick_limit: TICK_LIMIT_RST,
                   command_codes: '0, command_valid: '0};
      clear_frame_state();
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: kind %0d status %0d param 0x%0h",
                 out_ch.kind, out_ch.status, out_ch.param_byte);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("param_byte", want.param_byte, out_ch.param_byte);
          check_field("status", want.status, out_ch.status);
          check_field("frame_command", want.frame_command, out_ch.frame_command);
          check_field("command_slot", want.command_slot, out_ch.command_slot);
          check_field("packet_number", want.packet_number, out_ch.packet_number);
        end
      end
      if (in_ch.valid && in_ch.ready && predict_item(in_ch.cmd, in_ch.rx_byte, nxt))
        expected_results.push_back(nxt);
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_SYNC_FIRST:    cfg_regs.sync_first       = pwdata[7:0];
          REG_SYNC_SECOND:   cfg_regs.sync_second      = pwdata[7:0];
          REG_HUNT_LIMIT:    cfg_regs.hunt_tick_limit  = pwdata;
          REG_FRAME_LIMIT:   cfg_regs.frame_tick_limit = pwdata;
          REG_COMMAND_CODES: cfg_regs.command_codes    = pwdata;
          REG_COMMAND_VALID: cfg_regs.command_valid    = pwdata[3:0];
          default: ;
        endcase
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives bytes, idle ticks and register writes into the command frame
// receiver; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top import scfr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS  = 205;   // random items per register setting
  localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
  localparam int END_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst_n;

  scfr_in_if  in_ch ();
  scfr_out_if out_ch ();

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int        send_idle_pct;
  int        recv_idle_pct;
  int        items_sent   = 0;
  int        stall_cycles = 0;
  int        check_fails;
  int        check_pending;
  scfr_cfg_t cur_cfg;

  always #5 clk = ~clk;

  serial_command_frame_receiver_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scfr_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (check_fails),
    .pending_count (check_pending)
  );

  // watchdog: any handshake on any port restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[serial_command_frame_receiver_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: ready dropped at random, one update per falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one item, with random idle cycles ahead of it; returns at the falling
  // edge after acceptance with valid still high
  task automatic push_item(logic c, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // sender goes quiet until every predicted result has come out
  task automatic wait_results_done(int extra);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (check_pending != 0);
    repeat (extra) @(negedge clk);
  endtask

  // setup phase, access phase, then psel low again so writes never collide
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_cfg(scfr_cfg_t c);
    cur_cfg = c;
    reg_write(REG_SYNC_FIRST, 32'(c.sync_first));
    reg_write(REG_SYNC_SECOND, 32'(c.sync_second));
    reg_write(REG_HUNT_LIMIT, c.hunt_tick_limit);
    reg_write(REG_FRAME_LIMIT, c.frame_tick_limit);
    reg_write(REG_COMMAND_CODES, c.command_codes);
    reg_write(REG_COMMAND_VALID, 32'(c.command_valid));
  endtask

  // mostly a command that sits in some slot, sometimes anything
  function automatic logic [7:0] pick_command();
    if ($urandom_range(3) != 0) return cur_cfg.command_codes[8*$urandom_range(3) +: 8];
    return 8'($urandom);
  endfunction

  // full frame with the current sync bytes; a bad length stops after the
  // length byte, cut keeps only the first bytes, ticks may be mixed in
  task automatic send_frame(logic [7:0] fcmd, logic [7:0] pkt, logic [7:0] len,
                            bit bad_crc, int tick_pct, int cut);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    fb = '{cur_cfg.sync_first, cur_cfg.sync_second, fcmd, pkt, len};
    if (len >= LEN_MIN && len <= LEN_MAX) begin
      while (fb.size() < len) fb.push_back(8'($urandom));
      crc = '0;
      foreach (fb[i]) crc = crc_byte(crc, fb[i]);
      // flip one bit of either crc byte
      if (bad_crc) crc ^= 16'(1) << $urandom_range(15);
      fb.push_back(crc[15:8]);
      fb.push_back(crc[7:0]);
    end
    if (cut > 0 && cut < fb.size()) fb = fb[0:cut-1];
    foreach (fb[i]) begin
      while ($urandom_range(99) < tick_pct) push_item(CMD_TICK, 8'($urandom));
      push_item(CMD_BYTE, fb[i]);
    end
  endtask

  initial begin
    scfr_cfg_t  plan;
    int         phase_end;
    int         sel;
    logic [7:0] len;

    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.rx_byte = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_n         = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 55;
    cur_cfg       = '0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      // register settings: default sync bytes, zero limits, equal sync bytes,
      // saturated limits, random, and tight limits
      case (ph)
        0: plan = '{sync_first: 8'h1b, sync_second: 8'h10, hunt_tick_limit: 32'd6,
                    frame_tick_limit: 32'd10, command_codes: 32'h44332211,
                    command_valid: 4'hf};
        1: plan = '{sync_first: 8'h00, sync_second: 8'hff, hunt_tick_limit: 32'd0,
                    frame_tick_limit: 32'd0, command_codes: 32'h5a5a5a5a,
                    command_valid: 4'ha};
        2: plan = '{sync_first: 8'ha5, sync_second: 8'ha5, hunt_tick_limit: 32'd3,
                    frame_tick_limit: 32'd25, command_codes: 32'($urandom),
                    command_valid: 4'h5};
        3: plan = '{sync_first: 8'hff, sync_second: 8'h00, hunt_tick_limit: '1,
                    frame_tick_limit: '1, command_codes: 32'($urandom),
                    command_valid: 4'h0};
        4: plan = '{sync_first: 8'($urandom), sync_second: 8'($urandom),
                    hunt_tick_limit: 32'd8, frame_tick_limit: 32'd40,
                    command_codes: 32'($urandom), command_valid: 4'($urandom)};
        default: plan = '{sync_first: 8'h7e, sync_second: 8'h81, hunt_tick_limit: 32'd2,
                          frame_tick_limit: 32'd6, command_codes: 32'h00ff7f80,
                          command_valid: 4'hf};
      endcase

      // idling: sender light / receiver heavy, then swapped, then none
      if (ph == 2) begin
        send_idle_pct = 55;
        recv_idle_pct = 16;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // registers only change with the pipe empty
      wait_results_done(DRAIN_CYCLES);
      apply_cfg(plan);

      if (ph == 0) begin
        // repeated first sync, one parameter byte, more packets follow
        push_item(CMD_BYTE, cur_cfg.sync_first);
        send_frame(8'h33, 8'hff, 8'd6, 1'b0, 0, 0);
        // shortest frame, last packet
        send_frame(8'h11, 8'h00, LEN_MIN, 1'b0, 0, 0);
        // length below the minimum
        send_frame(8'h22, 8'h01, LEN_MIN - 8'd1, 1'b0, 0, 0);
        // one tick past the hunt limit gives no-data status
        repeat (7) push_item(CMD_TICK, 8'hff);
        wait_results_done(0);
      end

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          // tick burst, crosses the limits in most settings
          repeat ($urandom_range(1, 12)) push_item(CMD_TICK, 8'($urandom));
        end else if (sel < 16) begin
          // line noise, often the first sync byte to arm and disarm
          repeat ($urandom_range(1, 3))
            push_item(CMD_BYTE, $urandom_range(1) ? cur_cfg.sync_first : 8'($urandom));
        end else if (sel < 22) begin
          // length out of range on either side
          len = $urandom_range(1) ? 8'($urandom_range(LEN_MIN - 1)) : LEN_MAX + 8'd1;
          send_frame(pick_command(), 8'($urandom), len, 1'b0, 0, 0);
        end else if (sel < 24) begin
          wait_results_done(0);
        end else if (sel < 34) begin
          // frame cut short, then ticks for header or body timeout
          len = 8'($urandom_range(LEN_MIN, LEN_MIN + 6));
          send_frame(pick_command(), 8'($urandom), len, 1'b0, 0,
                     $urandom_range(1, int'(len) + 1));
          repeat ($urandom_range(1, 30)) push_item(CMD_TICK, 8'($urandom));
        end else begin
          // well-formed frame, now and then long or with a broken crc
          if ($urandom_range(39) == 0)
            len = $urandom_range(1) ? LEN_MAX : 8'($urandom_range(LEN_MIN, LEN_MAX));
          else
            len = 8'($urandom_range(LEN_MIN, LEN_MIN + 6));
          send_frame(pick_command(), $urandom_range(2) == 0 ? 8'h00 : 8'($urandom), len,
                     $urandom_range(6) == 0, $urandom_range(3) == 0 ? 4 : 0, 0);
        end
      end
    end

    wait_results_done(END_CYCLES);
    if (check_fails == 0 && check_pending == 0) begin
      $display("[serial_command_frame_receiver_core] OK");
    end else begin
      $display("[serial_command_frame_receiver_core] ERROR");
    end
    $finish;
  end

endmodule
